// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NSFP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NSFP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/nsfp_pkg.sv =====
`default_nettype none

package nsfp_pkg;

    localparam int VALUE_BITS      = 40;
    localparam int FRACTION_DIGITS = 5;
    localparam int OUT_BITS        = 40;
    localparam int ACC_W           = VALUE_BITS + 4;
    localparam int POW_BITS        = $clog2(10 ** FRACTION_DIGITS + 1);
    localparam int PROD_BITS       = VALUE_BITS + POW_BITS;
    localparam int FDC_BITS        = $clog2(FRACTION_DIGITS + 1);
    localparam int HDR_LEN         = 5;
    localparam int HDR_BITS        = 8 * HDR_LEN;
    localparam int HPOS_BITS       = $clog2(HDR_LEN + 1);
    localparam int FIELD_BITS      = 5;
    localparam int NUM_SLOTS       = 5;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QP_BITS         = $clog2(QUEUE_DEPTH);
    localparam int QC_BITS         = $clog2(QUEUE_DEPTH + 1);

    localparam logic [VALUE_BITS-1:0] MAG_TOP = VALUE_BITS'(1) << (VALUE_BITS - 1);

    // Characters
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Headers, first character in the high byte
    localparam logic [HDR_BITS-1:0] HDR_GGA = "GPGGA";
    localparam logic [HDR_BITS-1:0] HDR_RMC = "GPRMC";
    localparam logic [HDR_BITS-1:0] HDR_GSA = "GPGSA";
    localparam logic [HDR_BITS-1:0] HDR_GLL = "GPGLL";
    localparam logic [HDR_BITS-1:0] HDR_VTG = "GPVTG";
    localparam logic [HDR_BITS-1:0] HDR_TXT = "GPTXT";

    // Field positions of interest
    localparam logic [FIELD_BITS-1:0] GGA_LAT_FIELD = FIELD_BITS'(2);
    localparam logic [FIELD_BITS-1:0] GGA_LON_FIELD = FIELD_BITS'(4);
    localparam logic [FIELD_BITS-1:0] GGA_ALT_FIELD = FIELD_BITS'(9);
    localparam logic [FIELD_BITS-1:0] RMC_LAT_FIELD = FIELD_BITS'(3);
    localparam logic [FIELD_BITS-1:0] RMC_LON_FIELD = FIELD_BITS'(5);
    localparam logic [FIELD_BITS-1:0] RMC_SPD_FIELD = FIELD_BITS'(7);
    localparam logic [FIELD_BITS-1:0] RMC_CRS_FIELD = FIELD_BITS'(8);

    typedef enum logic [2:0] {
        KIND_GGA  = 3'd0,
        KIND_RMC  = 3'd1,
        KIND_GSA  = 3'd2,
        KIND_GLL  = 3'd3,
        KIND_VTG  = 3'd4,
        KIND_TXT  = 3'd5,
        KIND_NONE = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        SLOT_LAT  = 3'd0,
        SLOT_LON  = 3'd1,
        SLOT_ALT  = 3'd2,
        SLOT_SPD  = 3'd3,
        SLOT_CRS  = 3'd4,
        SLOT_NONE = 3'd5
    } slot_t;

    typedef enum logic [1:0] {
        OP_OPEN  = 2'd0,
        OP_FIELD = 2'd1,
        OP_END   = 2'd2
    } op_code_t;

    typedef logic [OUT_BITS-1:0] value_t;

    // One queued command from the front to the back
    typedef struct packed {
        op_code_t                code;
        kind_t                   kind;
        slot_t                   slot;
        logic                    sign;
        logic [POW_BITS-1:0]     scale;
        logic [VALUE_BITS-1:0]   acc;
    } op_t;

    function automatic kind_t kind_of(input logic [HDR_BITS-1:0] hdr,
                                      input logic [HPOS_BITS-1:0] pos);
        kind_t k;
        k = KIND_NONE;
        if (pos == HPOS_BITS'(HDR_LEN)) begin
            if (hdr == HDR_GGA)      k = KIND_GGA;
            else if (hdr == HDR_RMC) k = KIND_RMC;
            else if (hdr == HDR_GSA) k = KIND_GSA;
            else if (hdr == HDR_GLL) k = KIND_GLL;
            else if (hdr == HDR_VTG) k = KIND_VTG;
            else if (hdr == HDR_TXT) k = KIND_TXT;
        end
        return k;
    endfunction

    function automatic slot_t slot_of(input kind_t kind,
                                      input logic [FIELD_BITS-1:0] fidx);
        slot_t s;
        s = SLOT_NONE;
        case (kind)
            KIND_GGA:
            begin
                if (fidx == GGA_LAT_FIELD)      s = SLOT_LAT;
                else if (fidx == GGA_LON_FIELD) s = SLOT_LON;
                else if (fidx == GGA_ALT_FIELD) s = SLOT_ALT;
            end
            KIND_RMC:
            begin
                if (fidx == RMC_LAT_FIELD)      s = SLOT_LAT;
                else if (fidx == RMC_LON_FIELD) s = SLOT_LON;
                else if (fidx == RMC_SPD_FIELD) s = SLOT_SPD;
                else if (fidx == RMC_CRS_FIELD) s = SLOT_CRS;
            end
            default:
            begin
                s = SLOT_NONE;
            end
        endcase
        return s;
    endfunction

    // 10 to the power of the missing fraction digits
    function automatic logic [POW_BITS-1:0] pow10_sel(input logic [FDC_BITS-1:0] fdc);
        logic [POW_BITS-1:0] r;
        r = POW_BITS'(1);
        for (int i = 0; i < FRACTION_DIGITS; i++) begin
            if (FDC_BITS'(i) >= fdc) r = POW_BITS'(r * 10);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/nmea_sentence_field_parser_top.sv =====
// Channel  Dir  Handshake                     Payload
// text     in   text_valid / text_stall       text_byte[7:0]
// result   out  result_valid / result_stall   sentence_kind[2:0], five 40-bit values
//
// Throughput is one text byte per cycle while text_stall is low.
// A result reaches result_valid after its newline passes through the 4-entry
// command queue, the back's scale multiplier stage and the output register.
// text_stall rises only while the command queue is full, which happens only
// when result_stall holds a finished result in the output register.
// rst_n clears all parser state, the queue and the held sample asynchronously.
`default_nettype none

module nmea_sentence_field_parser_top import nsfp_pkg::*; (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       text_valid,
    output logic                       text_stall,
    input  logic [7:0]                 text_byte,
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic [2:0]                 sentence_kind,
    output logic signed [OUT_BITS-1:0] latitude_value,
    output logic signed [OUT_BITS-1:0] longitude_value,
    output logic signed [OUT_BITS-1:0] altitude_value,
    output logic signed [OUT_BITS-1:0] speed_value,
    output logic signed [OUT_BITS-1:0] course_value
);

    // Front -> queue
    logic push;
    op_t  push_op;
    logic q_full;

    // Queue -> back
    logic pop;
    op_t  head_op;
    logic q_empty;

    // Front: classify each byte, track header and field, build the number,
    // and push open / field / end commands.
    nsfp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (text_valid),
        .byte_data  (text_byte),
        .byte_stall (text_stall),
        .q_full     (q_full),
        .push       (push),
        .push_op    (push_op)
    );

    // Queue: decouple the front from output back-pressure.
    nsfp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .full    (q_full),
        .pop     (pop),
        .head_op (head_op),
        .empty   (q_empty)
    );

    // Back: scale fields by the missing fraction digits, saturate, update the
    // pending and held samples, and emit one result per sentence end.
    nsfp_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_op         (head_op),
        .q_empty         (q_empty),
        .pop             (pop),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .sentence_kind   (sentence_kind),
        .latitude_value  (latitude_value),
        .longitude_value (longitude_value),
        .altitude_value  (altitude_value),
        .speed_value     (speed_value),
        .course_value    (course_value)
    );

endmodule

`default_nettype wire

// ===== rtl/nsfp_front.sv =====
`default_nettype none

module nsfp_front import nsfp_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    input  logic [7:0] byte_data,
    output logic       byte_stall,
    input  logic       q_full,
    output logic       push,
    output op_t        push_op
);

    logic                  in_sent_reg, in_sent_next;
    logic [HDR_BITS-1:0]   hdr_reg, hdr_next;
    logic [HPOS_BITS-1:0]  hpos_reg, hpos_next;
    logic [FIELD_BITS-1:0] fidx_reg, fidx_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic                  sign_reg, sign_next;
    logic                  point_reg, point_next;
    logic                  stop_reg, stop_next;
    logic                  star_reg, star_next;
    logic [FDC_BITS-1:0]   fdc_reg, fdc_next;

    logic                  take;
    kind_t                 kind;
    slot_t                 slot;
    logic [VALUE_BITS-1:0] cap;
    logic [ACC_W-1:0]      ttp_wide;
    logic [VALUE_BITS-1:0] ttp;
    logic                  is_digit;

    assign byte_stall = q_full;
    assign take       = byte_valid && !q_full;
    assign kind       = kind_of(hdr_reg, hpos_reg);
    assign slot       = slot_of(kind, fidx_reg);
    assign cap        = sign_reg ? MAG_TOP : MAG_TOP - VALUE_BITS'(1);
    assign is_digit   = (byte_data >= CH_ZERO) && (byte_data <= CH_NINE);

    // acc * 10 + digit, saturating at the cap
    always_comb
    begin
        ttp_wide = (ACC_W'(acc_reg) << 3) + (ACC_W'(acc_reg) << 1)
                 + ACC_W'(4'(byte_data - CH_ZERO));
        ttp = (ttp_wide > ACC_W'(cap)) ? cap : ttp_wide[VALUE_BITS-1:0];
    end

    always_comb
    begin
        in_sent_next = in_sent_reg;
        hdr_next     = hdr_reg;
        hpos_next    = hpos_reg;
        fidx_next    = fidx_reg;
        acc_next     = acc_reg;
        sign_next    = sign_reg;
        point_next   = point_reg;
        stop_next    = stop_reg;
        star_next    = star_reg;
        fdc_next     = fdc_reg;

        push          = 1'b0;
        push_op.code  = OP_FIELD;
        push_op.kind  = kind;
        push_op.slot  = slot;
        push_op.sign  = sign_reg;
        push_op.scale = pow10_sel(fdc_reg);
        push_op.acc   = acc_reg;

        if (take) begin
            if (byte_data == CH_DOLLAR) begin
                push         = 1'b1;
                push_op.code = OP_OPEN;
                in_sent_next = 1'b1;
                hdr_next     = '0;
                hpos_next    = '0;
                fidx_next    = '0;
                acc_next     = '0;
                sign_next    = 1'b0;
                point_next   = 1'b0;
                stop_next    = 1'b0;
                star_next    = 1'b0;
                fdc_next     = '0;
            end else if (in_sent_reg) begin
                if (byte_data == CH_LF) begin
                    // close the open field unless a checksum already closed it
                    push         = 1'b1;
                    push_op.code = OP_END;
                    if (star_reg) push_op.slot = SLOT_NONE;
                    in_sent_next = 1'b0;
                end else if (!star_reg) begin
                    if (byte_data == CH_STAR || byte_data == CH_COMMA) begin
                        push       = (slot != SLOT_NONE);
                        acc_next   = '0;
                        sign_next  = 1'b0;
                        point_next = 1'b0;
                        stop_next  = 1'b0;
                        fdc_next   = '0;
                        if (byte_data == CH_STAR) begin
                            star_next = 1'b1;
                        end else if (fidx_reg != '1) begin
                            fidx_next = fidx_reg + FIELD_BITS'(1);
                        end
                    end else if (fidx_reg == '0) begin
                        if (hpos_reg < HPOS_BITS'(HDR_LEN)) begin
                            hdr_next  = {hdr_reg[HDR_BITS-9:0], byte_data};
                            hpos_next = hpos_reg + HPOS_BITS'(1);
                        end
                    end else if (!stop_reg) begin
                        if (is_digit) begin
                            if (!point_reg) begin
                                acc_next = ttp;
                            end else if (fdc_reg < FDC_BITS'(FRACTION_DIGITS)) begin
                                acc_next = ttp;
                                fdc_next = fdc_reg + FDC_BITS'(1);
                            end
                        end else if (byte_data == CH_DOT && !point_reg) begin
                            point_next = 1'b1;
                        end else if ((byte_data == CH_MINUS || byte_data == CH_PLUS)
                                     && acc_reg == '0 && !point_reg && !sign_reg) begin
                            if (byte_data == CH_MINUS) sign_next = 1'b1;
                        end else begin
                            stop_next = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_sent_reg <= 1'b0;
            hdr_reg     <= '0;
            hpos_reg    <= '0;
            fidx_reg    <= '0;
            acc_reg     <= '0;
            sign_reg    <= 1'b0;
            point_reg   <= 1'b0;
            stop_reg    <= 1'b0;
            star_reg    <= 1'b0;
            fdc_reg     <= '0;
        end else begin
            in_sent_reg <= in_sent_next;
            hdr_reg     <= hdr_next;
            hpos_reg    <= hpos_next;
            fidx_reg    <= fidx_next;
            acc_reg     <= acc_next;
            sign_reg    <= sign_next;
            point_reg   <= point_next;
            stop_reg    <= stop_next;
            star_reg    <= star_next;
            fdc_reg     <= fdc_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/nsfp_queue.sv =====
`default_nettype none

module nsfp_queue import nsfp_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    output logic full,
    input  logic pop,
    output op_t  head_op,
    output logic empty
);

    op_t                  mem_reg [QUEUE_DEPTH];
    logic [QP_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QP_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QC_BITS-1:0]   count_reg, count_next;
    logic                 do_push;
    logic                 do_pop;

    assign full    = (count_reg == QC_BITS'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign head_op = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QP_BITS'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QP_BITS'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QP_BITS'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QP_BITS'(1);
        end
        if (do_push && !do_pop) count_next = count_reg + QC_BITS'(1);
        else if (do_pop && !do_push) count_next = count_reg - QC_BITS'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push) mem_reg[wr_ptr_reg] <= push_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/nsfp_back.sv =====
`default_nettype none

module nsfp_back import nsfp_pkg::*; (
    input  logic                       clk,
    input  logic                       rst_n,
    input  op_t                        head_op,
    input  logic                       q_empty,
    output logic                       pop,
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic [2:0]                 sentence_kind,
    output logic signed [OUT_BITS-1:0] latitude_value,
    output logic signed [OUT_BITS-1:0] longitude_value,
    output logic signed [OUT_BITS-1:0] altitude_value,
    output logic signed [OUT_BITS-1:0] speed_value,
    output logic signed [OUT_BITS-1:0] course_value
);

    // scale stage
    logic                  a_valid_reg, a_valid_next;
    op_t                   a_op_reg;
    logic [PROD_BITS-1:0]  a_prod_reg;

    value_t                pend_reg [NUM_SLOTS];
    value_t                pend_next [NUM_SLOTS];
    value_t                held_reg [NUM_SLOTS];
    value_t                held_next [NUM_SLOTS];

    logic                  res_valid_reg, res_valid_next;
    kind_t                 res_kind_reg;
    value_t                res_val_reg [NUM_SLOTS];

    logic                  retire;
    logic                  load_result;
    logic [VALUE_BITS-1:0] cap;
    logic [VALUE_BITS-1:0] mag;
    logic [VALUE_BITS-1:0] sval;
    value_t                field_val;

    assign retire = a_valid_reg
                  && (a_op_reg.code != OP_END || !res_valid_reg || !result_stall);
    assign pop          = !q_empty && (!a_valid_reg || retire);
    assign a_valid_next = pop ? 1'b1 : (retire ? 1'b0 : a_valid_reg);
    assign load_result  = retire && (a_op_reg.code == OP_END);

    // saturate, apply sign, fit to the output width
    always_comb
    begin
        cap       = a_op_reg.sign ? MAG_TOP : MAG_TOP - VALUE_BITS'(1);
        mag       = (a_prod_reg > PROD_BITS'(cap)) ? cap : a_prod_reg[VALUE_BITS-1:0];
        sval      = a_op_reg.sign ? (VALUE_BITS'(0) - mag) : mag;
        field_val = OUT_BITS'($signed(sval));
    end

    always_comb
    begin
        pend_next = pend_reg;
        held_next = held_reg;
        if (retire) begin
            case (a_op_reg.code)
                OP_OPEN:
                begin
                    for (int i = 0; i < NUM_SLOTS; i++) pend_next[i] = '0;
                end
                OP_FIELD, OP_END:
                begin
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (a_op_reg.slot == slot_t'(i)) pend_next[i] = field_val;
                    end
                    if (a_op_reg.code == OP_END) begin
                        if (a_op_reg.kind == KIND_GGA) begin
                            held_next         = pend_next;
                            held_next[SLOT_SPD] = '0;
                            held_next[SLOT_CRS] = '0;
                        end else if (a_op_reg.kind == KIND_RMC) begin
                            held_next         = pend_next;
                            held_next[SLOT_ALT] = '0;
                        end
                    end
                end
                default:
                begin
                    pend_next = pend_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (load_result) res_valid_next = 1'b1;
        else if (res_valid_reg && !result_stall) res_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop) begin
            a_op_reg   <= head_op;
            a_prod_reg <= PROD_BITS'(head_op.acc) * PROD_BITS'(head_op.scale);
        end
        if (load_result) begin
            res_kind_reg <= a_op_reg.kind;
            res_val_reg  <= held_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            a_valid_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                pend_reg[i] <= '0;
                held_reg[i] <= '0;
            end
        end else begin
            a_valid_reg   <= a_valid_next;
            res_valid_reg <= res_valid_next;
            pend_reg      <= pend_next;
            held_reg      <= held_next;
        end
    end

    assign result_valid    = res_valid_reg;
    assign sentence_kind   = res_kind_reg;
    assign latitude_value  = res_val_reg[SLOT_LAT];
    assign longitude_value = res_val_reg[SLOT_LON];
    assign altitude_value  = res_val_reg[SLOT_ALT];
    assign speed_value     = res_val_reg[SLOT_SPD];
    assign course_value    = res_val_reg[SLOT_CRS];

endmodule

`default_nettype wire

// ===== rtl/nsfp_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module nsfp_checker import nsfp_pkg::*; (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       text_valid,
    input wire logic                       text_stall,
    input wire logic [7:0]                 text_byte,
    input wire logic                       result_valid,
    input wire logic                       result_stall,
    input wire logic [2:0]                 sentence_kind,
    input wire logic signed [OUT_BITS-1:0] latitude_value,
    input wire logic signed [OUT_BITS-1:0] longitude_value,
    input wire logic signed [OUT_BITS-1:0] altitude_value,
    input wire logic signed [OUT_BITS-1:0] speed_value,
    input wire logic signed [OUT_BITS-1:0] course_value
);

    // hold a stalled result
    `NSFP_ASSERT_NXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(sentence_kind) && $stable(latitude_value) && $stable(course_value), "stalled result changed")
    `NSFP_ASSERT_IMP(a_kind_range, clk, rst_n, result_valid, sentence_kind <= KIND_NONE, "sentence kind out of range")
    `NSFP_ASSERT_IMP(a_gga_clears, clk, rst_n, result_valid && sentence_kind == KIND_GGA, speed_value == '0 && course_value == '0, "GGA result with speed or course set")
    `NSFP_ASSERT_IMP(a_rmc_clears, clk, rst_n, result_valid && sentence_kind == KIND_RMC, altitude_value == '0, "RMC result with altitude set")

endmodule

bind nmea_sentence_field_parser_top nsfp_checker u_nsfp_checker (.*);

`default_nettype wire

// ===== tb/nsfp_fix_monitor.sv =====
`timescale 1ns / 100ps

module nsfp_fix_monitor import nsfp_pkg::*; (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       text_valid,
    input  logic                       text_stall,
    input  logic [7:0]                 text_byte,
    input  logic                       result_valid,
    input  logic                       result_stall,
    input  logic [2:0]                 sentence_kind,
    input  logic signed [OUT_BITS-1:0] latitude_value,
    input  logic signed [OUT_BITS-1:0] longitude_value,
    input  logic signed [OUT_BITS-1:0] altitude_value,
    input  logic signed [OUT_BITS-1:0] speed_value,
    input  logic signed [OUT_BITS-1:0] course_value,
    output int                         fail_count,
    output int                         open_count
);

    typedef struct packed {
        kind_t                     kind;
        value_t [NUM_SLOTS-1:0]    vals;
    } fix_t;

    localparam int FIELD_MAX = 31;

    string slot_names [NUM_SLOTS] = '{"latitude", "longitude", "altitude", "speed", "course"};

    // Parser state
    logic          in_sent;
    logic [7:0]    hdr [HDR_LEN];
    int unsigned   hdr_len;
    int unsigned   field_no;
    logic [63:0]   mag_acc;
    logic          neg;
    logic          point_seen;
    logic          stopped;
    logic          star_seen;
    int unsigned   frac_count;
    value_t        pend [NUM_SLOTS];
    value_t        held [NUM_SLOTS];

    fix_t          fixes_due [$];
    int            miss_total = 0;
    int            result_no  = 0;

    function automatic logic [63:0] mag_limit();
        logic [63:0] top;
        top = 64'd1 << (VALUE_BITS - 1);
        return neg ? top : top - 64'd1;
    endfunction

    // Multiply by ten and add a digit, pinned at the magnitude limit
    function automatic logic [63:0] shift_in_digit(input logic [63:0] v, input logic [63:0] d,
                                                   input logic [63:0] cap);
        if (v > (cap - d) / 64'd10)
            return cap;
        return v * 64'd10 + d;
    endfunction

    function automatic kind_t header_kind();
        logic [HDR_BITS-1:0] word;
        if (hdr_len < HDR_LEN)
            return KIND_NONE;
        word = {hdr[0], hdr[1], hdr[2], hdr[3], hdr[4]};
        case (word)
            HDR_GGA: return KIND_GGA;
            HDR_RMC: return KIND_RMC;
            HDR_GSA: return KIND_GSA;
            HDR_GLL: return KIND_GLL;
            HDR_VTG: return KIND_VTG;
            HDR_TXT: return KIND_TXT;
            default: return KIND_NONE;
        endcase
    endfunction

    function automatic slot_t field_slot(input kind_t k, input int unsigned f);
        if (k == KIND_GGA)
        begin
            if (f == GGA_LAT_FIELD) return SLOT_LAT;
            if (f == GGA_LON_FIELD) return SLOT_LON;
            if (f == GGA_ALT_FIELD) return SLOT_ALT;
        end
        else if (k == KIND_RMC)
        begin
            if (f == RMC_LAT_FIELD) return SLOT_LAT;
            if (f == RMC_LON_FIELD) return SLOT_LON;
            if (f == RMC_SPD_FIELD) return SLOT_SPD;
            if (f == RMC_CRS_FIELD) return SLOT_CRS;
        end
        return SLOT_NONE;
    endfunction

    // Scale the finished number, store it if the field is wanted, clear the number
    function automatic void close_field();
        logic [63:0] cap;
        logic [63:0] mag;
        logic [63:0] val;
        slot_t       s;
        int unsigned i;
        if (field_no > 0)
        begin
            cap = mag_limit();
            mag = mag_acc;
            for (i = frac_count; i < FRACTION_DIGITS; i++)
                mag = shift_in_digit(mag, 64'd0, cap);
            val = neg ? 64'd0 - mag : mag;
            s = field_slot(header_kind(), field_no);
            if (s != SLOT_NONE)
                pend[s] = val[OUT_BITS-1:0];
        end
        mag_acc = '0;
        neg = 1'b0;
        point_seen = 1'b0;
        stopped = 1'b0;
        frac_count = 0;
    endfunction

    function automatic void open_sentence();
        int i;
        in_sent = 1'b1;
        for (i = 0; i < HDR_LEN; i++)
            hdr[i] = '0;
        hdr_len = 0;
        field_no = 0;
        mag_acc = '0;
        neg = 1'b0;
        point_seen = 1'b0;
        stopped = 1'b0;
        star_seen = 1'b0;
        frac_count = 0;
        for (i = 0; i < NUM_SLOTS; i++)
            pend[i] = '0;
    endfunction

    // Advance the parser by one character; return 1 when a fix is due
    function automatic bit parse_char(input logic [7:0] c, output fix_t fix);
        kind_t k;
        int    i;
        fix = '0;
        if (c == CH_DOLLAR)
        begin
            open_sentence();
            return 1'b0;
        end
        if (!in_sent)
            return 1'b0;
        if (c == CH_LF)
        begin
            if (!star_seen)
                close_field();
            k = header_kind();
            if (k == KIND_GGA)
            begin
                held[SLOT_LAT] = pend[SLOT_LAT];
                held[SLOT_LON] = pend[SLOT_LON];
                held[SLOT_ALT] = pend[SLOT_ALT];
                held[SLOT_SPD] = '0;
                held[SLOT_CRS] = '0;
            end
            else if (k == KIND_RMC)
            begin
                held[SLOT_LAT] = pend[SLOT_LAT];
                held[SLOT_LON] = pend[SLOT_LON];
                held[SLOT_ALT] = '0;
                held[SLOT_SPD] = pend[SLOT_SPD];
                held[SLOT_CRS] = pend[SLOT_CRS];
            end
            fix.kind = k;
            for (i = 0; i < NUM_SLOTS; i++)
                fix.vals[i] = held[i];
            in_sent = 1'b0;
            return 1'b1;
        end
        if (star_seen)
            return 1'b0;
        if (c == CH_STAR)
        begin
            close_field();
            star_seen = 1'b1;
            return 1'b0;
        end
        if (c == CH_COMMA)
        begin
            close_field();
            if (field_no < FIELD_MAX)
                field_no++;
            return 1'b0;
        end
        if (field_no == 0)
        begin
            if (hdr_len < HDR_LEN)
            begin
                hdr[hdr_len] = c;
                hdr_len++;
            end
            return 1'b0;
        end
        if (stopped)
            return 1'b0;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            if (!point_seen)
                mag_acc = shift_in_digit(mag_acc, 64'(c - CH_ZERO), mag_limit());
            else if (frac_count < FRACTION_DIGITS)
            begin
                mag_acc = shift_in_digit(mag_acc, 64'(c - CH_ZERO), mag_limit());
                frac_count++;
            end
        end
        else if (c == CH_DOT && !point_seen)
            point_seen = 1'b1;
        else if ((c == CH_MINUS || c == CH_PLUS) && mag_acc == 0 && !point_seen && !neg)
        begin
            if (c == CH_MINUS)
                neg = 1'b1;
        end
        else
            stopped = 1'b1;
        return 1'b0;
    endfunction

    function automatic void log_miss(input string msg);
        miss_total++;
        if (miss_total <= 10)
            $display("%s", msg);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        fix_t   fix;
        fix_t   want;
        value_t got [NUM_SLOTS];
        int     i;
        if (!rst_n)
        begin
            open_sentence();
            in_sent = 1'b0;
            for (i = 0; i < NUM_SLOTS; i++)
                held[i] = '0;
            fixes_due.delete();
            open_count <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (text_valid && !text_stall)
            begin
                if (parse_char(text_byte, fix))
                    fixes_due.push_back(fix);
            end
            if (result_valid && !result_stall)
            begin
                result_no++;
                got[SLOT_LAT] = latitude_value;
                got[SLOT_LON] = longitude_value;
                got[SLOT_ALT] = altitude_value;
                got[SLOT_SPD] = speed_value;
                got[SLOT_CRS] = course_value;
                if (fixes_due.size() == 0)
                    log_miss($sformatf("result %0d: unexpected, kind %0d", result_no,
                                       sentence_kind));
                else
                begin
                    want = fixes_due.pop_front();
                    if (sentence_kind !== want.kind)
                        log_miss($sformatf("result %0d: kind expected %0d, got %0d",
                                           result_no, want.kind, sentence_kind));
                    for (i = 0; i < NUM_SLOTS; i++)
                    begin
                        if (got[i] !== want.vals[i])
                            log_miss($sformatf("result %0d: %s expected %0d, got %0d",
                                               result_no, slot_names[i],
                                               $signed(want.vals[i]), $signed(got[i])));
                    end
                end
            end
            open_count <= fixes_due.size();
            fail_count <= miss_total;
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

    import nsfp_pkg::*;

    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam int         RAND_BYTES = 1150;
    localparam int         RAND_LINES = 12;

    // Clock and reset; reset is held low from time zero
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    // Block inputs start at known values
    logic       text_valid   = 1'b0;
    logic [7:0] text_byte    = 8'h00;
    logic       result_stall = 1'b0;

    logic                       text_stall;
    logic                       result_valid;
    logic [2:0]                 sentence_kind;
    logic signed [OUT_BITS-1:0] latitude_value;
    logic signed [OUT_BITS-1:0] longitude_value;
    logic signed [OUT_BITS-1:0] altitude_value;
    logic signed [OUT_BITS-1:0] speed_value;
    logic signed [OUT_BITS-1:0] course_value;

    int fail_count;
    int open_count;

    // Shared knobs: idle_on enables random gaps on both sides, hold_request
    // asks the receiver for one long hold-off
    bit idle_on      = 1'b1;
    bit hold_request = 1'b0;

    // Characters waiting to be sent
    logic [7:0] text_q [$];

    nmea_sentence_field_parser_top u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .text_valid      (text_valid),
        .text_stall      (text_stall),
        .text_byte       (text_byte),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .sentence_kind   (sentence_kind),
        .latitude_value  (latitude_value),
        .longitude_value (longitude_value),
        .altitude_value  (altitude_value),
        .speed_value     (speed_value),
        .course_value    (course_value)
    );

    nsfp_fix_monitor u_monitor (
        .clk             (clk),
        .rst_n           (rst_n),
        .text_valid      (text_valid),
        .text_stall      (text_stall),
        .text_byte       (text_byte),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .sentence_kind   (sentence_kind),
        .latitude_value  (latitude_value),
        .longitude_value (longitude_value),
        .altitude_value  (altitude_value),
        .speed_value     (speed_value),
        .course_value    (course_value),
        .fail_count      (fail_count),
        .open_count      (open_count)
    );

    // Append the characters of a string to the send queue
    function automatic void add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endfunction

    // Append raw bytes over the full 8-bit range; these may hit any control character
    function automatic void add_raw(input int n);
        int i;
        for (i = 0; i < n; i++)
            text_q.push_back(8'($urandom_range(255)));
    endfunction

    // Append one field: mostly well-formed numbers with random sign, leading
    // zeros, integer and fraction lengths; sometimes empty, oversized or junk
    function automatic void add_number();
        string s;
        int    r;
        int    n;
        int    i;
        s = "";
        r = $urandom_range(99);
        if (r < 8)
            return;
        if (r < 12)
        begin
            add_raw($urandom_range(1, 4));
            return;
        end
        r = $urandom_range(99);
        if (r < 12)
            s = "-";
        else if (r < 16)
            s = "+";
        else if (r < 18)
            s = "+-";
        else if (r < 20)
            s = "-+";
        if ($urandom_range(9) == 0)
            s = {s, "00"};
        n = ($urandom_range(19) == 0) ? $urandom_range(10, 18) : $urandom_range(0, 5);
        for (i = 0; i < n; i++)
            s = {s, $sformatf("%0d", $urandom_range(9))};
        if ($urandom_range(99) < 70)
        begin
            s = {s, "."};
            n = $urandom_range(0, 8);
            for (i = 0; i < n; i++)
                s = {s, $sformatf("%0d", $urandom_range(9))};
        end
        if ($urandom_range(19) == 0)
        begin
            r = $urandom_range(3);
            s = {s, (r == 0) ? "x" : (r == 1) ? "." : (r == 2) ? "-" : " "};
            s = {s, $sformatf("%0d", $urandom_range(9))};
        end
        add_text(s);
    endfunction

    // Queue one random sentence; return 1 if it was closed by a newline
    function automatic bit add_sentence();
        string hdr_pool;
        int    r;
        int    nf;
        int    i;
        hdr_pool = "GPRMCAXTLV";
        // a little noise between sentences
        if ($urandom_range(19) == 0)
            add_raw($urandom_range(1, 6));
        add_text("$");
        r = $urandom_range(99);
        if (r < 38)
        begin
            add_text("GPGGA");
            nf = 14;
        end
        else if (r < 76)
        begin
            add_text("GPRMC");
            nf = 12;
        end
        else if (r < 80)
        begin
            add_text("GPGSA");
            nf = 17;
        end
        else if (r < 84)
        begin
            add_text("GPGLL");
            nf = 6;
        end
        else if (r < 88)
        begin
            add_text("GPVTG");
            nf = 8;
        end
        else if (r < 92)
        begin
            add_text("GPTXT");
            nf = 4;
        end
        else
        begin
            // scrambled header of random length
            nf = $urandom_range(0, 7);
            for (i = 0; i < nf; i++)
                text_q.push_back(hdr_pool[$urandom_range(hdr_pool.len() - 1)]);
            nf = $urandom_range(0, 5);
        end
        // short or overlong field lists now and then
        if ($urandom_range(9) == 0)
            nf = $urandom_range(0, 20);
        for (i = 0; i < nf; i++)
        begin
            add_text(",");
            add_number();
        end
        if ($urandom_range(99) < 60)
            add_text($sformatf("*%02X", $urandom_range(255)));
        if ($urandom_range(99) < 40)
            text_q.push_back(CH_CR);
        // drop the newline sometimes, so the next '$' restarts the sentence
        if ($urandom_range(99) < 96)
        begin
            add_text("\n");
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Offer every queued character, with random gaps, and hold each until taken;
    // valid stays high after the last one so back-to-back calls stream
    task automatic send_text();
        logic [7:0] b;
        while (text_q.size() != 0)
        begin
            b = text_q.pop_front();
            while (idle_on && $urandom_range(99) < 12)
            begin
                text_valid <= 1'b0;
                @(posedge clk);
            end
            text_valid <= 1'b1;
            text_byte  <= b;
            do
                @(posedge clk);
            while (text_stall);
        end
    endtask

    // Drop valid and wait until every expected fix has come out
    task automatic drain_results();
        text_valid <= 1'b0;
        do
            @(posedge clk);
        while (open_count != 0);
    endtask

    // Result side: random stall, plus one long hold-off counted here when asked
    initial
    begin : receiver
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                result_stall <= 1'b1;
                hold_left--;
            end
            else
                result_stall <= idle_on && ($urandom_range(99) < 12);
        end
    end

    initial
    begin : stimulus
        int random_bytes;
        int random_lines;
        bit paused;
        int i;
        random_bytes = 0;
        random_lines = 0;
        paused       = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Every sentence kind with typical content
        add_text("$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47\n");
        add_text("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6A\n");
        add_text("$GPGSA,A,3,04,05,,09,12,,,24,,,,,2.5,1.3,2.1*39\n");
        add_text("$GPGLL,4916.45,N,12311.12,W,225444,A\n");
        add_text("$GPVTG,054.7,T,034.4,M,005.5,N,010.2,K\n");
        add_text("$GPTXT,01,01,02,ANTSTATUS=OK*3B\n");
        // unknown header, short header, prefix-only match, no comma at all
        add_text("$GPXYZ,1,2,3\n$GPG\n$GPGGAXY,1,2,3,4\n$GPRMC\n");
        // exact magnitude limits pass, one past them saturates
        add_text("$GPGGA,,5497558.13887,,-5497558.13888,,,,,99999999999999999999\n");
        add_text("$GPRMC,,,5497558.13888,,-99999999.9,,+12.5,-0.000001\n");
        // sign after leading zeros, plus then minus, minus then plus
        add_text("$GPGGA,,000-12.5,,+-7.25,,,,,-+3\n");
        // sign after a digit, second point, bare point, sign and point only
        add_text("$GPRMC,,,12-3,,1.2.3,,.5,-.\n");
        // extra fraction digits, junk inside a number, empty and missing fields
        add_text("$GPGGA,,1.23456789,,77a88,,,,,\n$GPGGA,1\n");
        // '$' inside a sentence restarts it; text outside any sentence is ignored
        add_text("$GPGGA,,11,,22$GPRMC,,,33,,44,,55,66\nnoise,123\n\n");
        // checksum closes the field and hides the rest
        add_text("$GPRMC,,,1.5*,9,9,9\n");
        // field count pins at its top value
        add_text("$GPGGA");
        for (i = 0; i < 40; i++)
            add_text(",");
        add_text("5\n");
        // carriage return stops a number; lowest and highest byte codes
        add_text("$GPGGA,,42.5");
        text_q.push_back(CH_CR);
        add_text("\n$GPGGA,,1");
        text_q.push_back(8'h00);
        add_text(",,2");
        text_q.push_back(8'hFF);
        add_text("\n");
        text_q.push_back(8'hFF);
        text_q.push_back(8'h00);
        send_text();

        // Sender pause: let every fix out before the random part
        drain_results();

        while (random_bytes < RAND_BYTES || random_lines < RAND_LINES)
        begin
            // a stretch with no gaps on either side
            idle_on = !(random_bytes >= 250 && random_bytes < 550);
            // the receiver holds off for a long time while characters keep coming
            if (random_bytes >= 650)
                hold_request = 1'b1;
            // a second sender pause in the middle of the random traffic
            if (random_bytes >= 900 && !paused)
            begin
                paused = 1'b1;
                drain_results();
            end
            random_lines += add_sentence();
            random_bytes += text_q.size();
            send_text();
        end

        drain_results();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && open_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Hard stop far beyond the slowest legal run
    initial
    begin : watchdog
        #1000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
